// ----- design/wscfr_pkg.sv -----
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Shared types and constants for the frame receiver.
// ----------------------------------------------------------------------------
`default_nettype none
package wscfr_pkg;

   typedef enum logic [1:0] {
      FUNC_BYTE  = 2'd0,
      FUNC_LCLOSE = 2'd1,
      FUNC_NEWCON = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [2:0] {
      EV_NONE     = 3'd0,
      EV_MSG_BYTE = 3'd1,
      EV_MSG_END  = 3'd2,
      EV_PONG     = 3'd3,
      EV_PONG_NIL = 3'd4,
      EV_CLOSE    = 3'd5,
      EV_PROTO    = 3'd6,
      EV_TOO_BIG  = 3'd7
   } event_type;

   localparam logic [15:0] CODE_NORMAL   = 16'd1000;
   localparam logic [15:0] CODE_PROTOCOL = 16'd1002;
   localparam logic [15:0] CODE_NONE     = 16'd1005;
   localparam logic [15:0] CODE_ABNORMAL = 16'd1006;
   localparam logic [15:0] CODE_TOO_BIG  = 16'd1009;
   localparam logic [31:0] MAX_MSG_RESET = 32'd1048576;

   localparam logic [3:0] OP_CONT  = 4'd0;
   localparam logic [3:0] OP_TEXT  = 4'd1;
   localparam logic [3:0] OP_BIN   = 4'd2;
   localparam logic [3:0] OP_CLOSE = 4'd8;
   localparam logic [3:0] OP_PING  = 4'd9;
   localparam logic [3:0] OP_PONG  = 4'd10;

   // queued item from front to back
   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
   } item_type;

   // one result item
   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  data_byte;
      logic        last_byte;
      logic        message_binary;
      logic [15:0] close_code;
      logic        send_close;
      logic [15:0] reply_code;
      logic        link_open;
   } result_type;

endpackage
`default_nettype wire

// ----- design/wscfr_queue.sv -----
// ----------------------------------------------------------------------------
// Item queue
// Two-entry queue that parts the input side from the parser.
// ----------------------------------------------------------------------------
`default_nettype none
module wscfr_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire wscfr_pkg::item_type  in_item,
   output logic                      out_valid,
   input  wire logic                 out_ready,
   output wscfr_pkg::item_type       out_item
);
   wscfr_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push = in_valid & in_ready;
   assign pop  = out_valid & out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop) rd_ptr_ff <= ~rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
      if (push) mem_ff[wr_ptr_ff] <= in_item;
   end
endmodule
`default_nettype wire

// ----- design/wscfr_parser.sv -----
// ----------------------------------------------------------------------------
// Frame parser
// Header parse and checks, payload routing, close and error handling.
// ----------------------------------------------------------------------------
`default_nettype none
module wscfr_parser #(
   parameter int MESSAGE_SIZE_BITS = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [31:0]           max_message_size,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire wscfr_pkg::item_type   in_item,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output wscfr_pkg::result_type      out_result
);
   typedef enum logic [2:0] {
      PH_HDR0, PH_HDR1, PH_EXT, PH_PAY, PH_DEAD
   } phase_type;

   localparam int TW = MESSAGE_SIZE_BITS;

   phase_type phase_ff, phase_in;
   logic        fin_ff, fin_in;
   logic [3:0]  op_ff, op_in;
   logic [2:0]  lbc_ff, lbc_in;
   logic [63:0] len_ff, len_in;
   logic [TW-1:0] tot_ff, tot_in;
   logic        inmsg_ff, inmsg_in;
   logic        bin_ff, bin_in;
   logic        csent_ff, csent_in;
   logic [15:0] rcode_ff, rcode_in;
   logic        rsv_ff, rsv_in;
   logic        mask_ff, mask_in;
   logic        ovalid_ff;
   wscfr_pkg::result_type res_ff, res_in;

   logic        take;
   logic [7:0]  b;
   logic [6:0]  l7;
   logic [63:0] hlen, ext_len, len_dec;
   logic [64:0] sum;
   logic        mask_now;
   logic        hdr_done, too_big, proto_err, op_ok, is_ctl;

   assign in_ready   = ~ovalid_ff | out_ready;
   assign take       = in_valid & in_ready;
   assign out_valid  = ovalid_ff;
   assign out_result = res_ff;
   assign b  = in_item.rx_byte;
   assign l7 = b[6:0];
   assign ext_len = {len_ff[55:0], b};
   assign len_dec = len_ff - 64'd1;
   assign hlen = (phase_ff == PH_HDR1) ? {57'd0, l7} : ext_len;
   assign mask_now = (phase_ff == PH_HDR1) ? b[7] : mask_ff;
   assign sum  = {{(65-TW){1'b0}}, tot_ff} + {1'b0, hlen};
   assign is_ctl = op_ff[3];
   assign too_big = (hlen > {32'd0, max_message_size}) |
                    (sum > {33'd0, max_message_size});
   always_comb begin
      unique case (op_ff)
         wscfr_pkg::OP_CONT:  op_ok = inmsg_ff;
         wscfr_pkg::OP_TEXT,
         wscfr_pkg::OP_BIN:   op_ok = ~inmsg_ff;
         wscfr_pkg::OP_CLOSE,
         wscfr_pkg::OP_PING,
         wscfr_pkg::OP_PONG:  op_ok = 1'b1;
         default:             op_ok = 1'b0;
      endcase
   end
   assign proto_err = hlen[63] | mask_now |
                      (is_ctl & (~fin_ff | (hlen > 64'd125)));

   always_comb begin
      phase_in = phase_ff; fin_in = fin_ff; op_in = op_ff; lbc_in = lbc_ff;
      len_in = len_ff; tot_in = tot_ff; inmsg_in = inmsg_ff; bin_in = bin_ff;
      csent_in = csent_ff; rcode_in = rcode_ff; rsv_in = rsv_ff; mask_in = mask_ff;
      res_in = '0;
      hdr_done = 1'b0;
      if (in_item.func == wscfr_pkg::FUNC_LCLOSE) begin
         csent_in = 1'b1;
      end else if (in_item.func == wscfr_pkg::FUNC_NEWCON) begin
         phase_in = PH_HDR0; fin_in = 1'b0; op_in = '0; lbc_in = '0; len_in = '0;
         tot_in = '0; inmsg_in = 1'b0; bin_in = 1'b0; csent_in = 1'b0;
         rcode_in = wscfr_pkg::CODE_ABNORMAL; rsv_in = 1'b0; mask_in = 1'b0;
      end else if (in_item.func == wscfr_pkg::FUNC_BYTE) begin
         unique case (phase_ff)
            PH_HDR0: begin
               fin_in = b[7]; op_in = b[3:0]; rsv_in = |b[6:4]; phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               if (rsv_ff) begin
                  res_in.event_res = wscfr_pkg::EV_PROTO;
                  res_in.send_close = ~csent_ff;
                  res_in.reply_code = csent_ff ? 16'd0 : wscfr_pkg::CODE_PROTOCOL;
                  csent_in = 1'b1; phase_in = PH_DEAD; inmsg_in = 1'b0; tot_in = '0;
               end else begin
                  mask_in = b[7];
                  len_in = {57'd0, l7};
                  if (l7 == 7'd126) begin
                     len_in = '0; lbc_in = 3'd1; phase_in = PH_EXT;
                  end else if (l7 == 7'd127) begin
                     len_in = '0; lbc_in = 3'd7; phase_in = PH_EXT;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_EXT: begin
               len_in = ext_len;
               if (lbc_ff == 3'd0) hdr_done = 1'b1;
               else lbc_in = lbc_ff - 3'd1;
            end
            PH_PAY: begin
               if (len_ff == 64'd0) begin
                  phase_in = PH_HDR0;
               end else begin
                  len_in = len_dec;
                  if (len_dec == 64'd0) phase_in = PH_HDR0;
                  if (!is_ctl) begin
                     res_in.event_res = wscfr_pkg::EV_MSG_BYTE;
                     res_in.data_byte = b;
                     res_in.message_binary = bin_ff;
                     res_in.last_byte = (len_dec == 64'd0) & fin_ff;
                     if ((len_dec == 64'd0) & fin_ff) begin
                        inmsg_in = 1'b0; tot_in = '0;
                     end
                  end else if (op_ff == wscfr_pkg::OP_CLOSE) begin
                     if (lbc_ff == 3'd0) begin
                        rcode_in = {b, 8'd0}; lbc_in = 3'd1;
                     end else if (lbc_ff == 3'd1) begin
                        rcode_in = {rcode_ff[15:8], b}; lbc_in = 3'd2;
                     end
                     if (len_dec == 64'd0) begin
                        if (lbc_in < 3'd2) rcode_in = wscfr_pkg::CODE_NONE;
                        res_in.event_res = wscfr_pkg::EV_CLOSE;
                        res_in.close_code = rcode_in;
                        res_in.send_close = ~csent_ff;
                        res_in.reply_code = csent_ff ? 16'd0 :
                           ((lbc_in < 3'd2) ? wscfr_pkg::CODE_NORMAL : rcode_in);
                        csent_in = 1'b1; phase_in = PH_DEAD; inmsg_in = 1'b0;
                        tot_in = '0;
                     end
                  end else if (op_ff == wscfr_pkg::OP_PING) begin
                     res_in.event_res = wscfr_pkg::EV_PONG;
                     res_in.data_byte = b;
                     res_in.last_byte = (len_dec == 64'd0);
                  end
               end
            end
            default: ;
         endcase
         if (hdr_done) begin
            if (proto_err | (~is_ctl & too_big) | ~op_ok) begin
               res_in.event_res = (~proto_err & ~is_ctl & too_big) ?
                  wscfr_pkg::EV_TOO_BIG : wscfr_pkg::EV_PROTO;
               res_in.send_close = ~csent_ff;
               res_in.reply_code = csent_ff ? 16'd0 :
                  ((~proto_err & ~is_ctl & too_big) ? wscfr_pkg::CODE_TOO_BIG :
                   wscfr_pkg::CODE_PROTOCOL);
               csent_in = 1'b1; phase_in = PH_DEAD; inmsg_in = 1'b0; tot_in = '0;
            end else begin
               if (op_ff == wscfr_pkg::OP_CONT) tot_in = sum[TW-1:0];
               if ((op_ff == wscfr_pkg::OP_TEXT) | (op_ff == wscfr_pkg::OP_BIN)) begin
                  bin_in = (op_ff == wscfr_pkg::OP_BIN);
                  inmsg_in = 1'b1;
                  tot_in = hlen[TW-1:0];
               end
               lbc_in = 3'd0;
               if (hlen != 64'd0) begin
                  phase_in = PH_PAY;
               end else begin
                  phase_in = PH_HDR0;
                  if (op_ff == wscfr_pkg::OP_CLOSE) begin
                     rcode_in = wscfr_pkg::CODE_NONE;
                     res_in.event_res = wscfr_pkg::EV_CLOSE;
                     res_in.close_code = wscfr_pkg::CODE_NONE;
                     res_in.send_close = ~csent_ff;
                     res_in.reply_code = csent_ff ? 16'd0 : wscfr_pkg::CODE_NORMAL;
                     csent_in = 1'b1; phase_in = PH_DEAD; inmsg_in = 1'b0;
                     tot_in = '0;
                  end else if (op_ff == wscfr_pkg::OP_PING) begin
                     res_in.event_res = wscfr_pkg::EV_PONG_NIL;
                  end else if (~is_ctl & fin_ff) begin
                     res_in.event_res = wscfr_pkg::EV_MSG_END;
                     res_in.message_binary = bin_in;
                     inmsg_in = 1'b0; tot_in = '0;
                  end
               end
            end
         end
      end
      res_in.link_open = (phase_in != PH_DEAD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR0; fin_ff <= 1'b0; op_ff <= '0; lbc_ff <= '0;
         len_ff <= '0; tot_ff <= '0; inmsg_ff <= 1'b0; bin_ff <= 1'b0;
         csent_ff <= 1'b0; rcode_ff <= wscfr_pkg::CODE_ABNORMAL;
         rsv_ff <= 1'b0; mask_ff <= 1'b0; ovalid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; fin_ff <= fin_in; op_ff <= op_in; lbc_ff <= lbc_in;
            len_ff <= len_in; tot_ff <= tot_in; inmsg_ff <= inmsg_in; bin_ff <= bin_in;
            csent_ff <= csent_in; rcode_ff <= rcode_in; rsv_ff <= rsv_in;
            mask_ff <= mask_in;
         end
         if (take) ovalid_ff <= 1'b1;
         else if (out_ready) ovalid_ff <= 1'b0;
      end
      if (take) res_ff <= res_in;
   end
endmodule
`default_nettype wire

// ----- design/websocket_client_frame_receiver.sv -----
// ----------------------------------------------------------------------------
// WebSocket client frame receiver
// Parses server-to-client frames one byte per item.
// ----------------------------------------------------------------------------
// Takes one item per cycle while results are accepted, and gives one result per
// item. Items pass a two-entry queue into the parser, which registers each
// result; a result is offered from the parser's result register once its item
// has passed the queue. Throughput is one item per cycle while rsp_tready is
// high, set by the header and payload update that the parser makes per item.
`default_nettype none
module websocket_client_frame_receiver #(
   parameter int MESSAGE_SIZE_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // rx_byte
   input  wire logic [1:0]  req_tuser,   // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // event_res, data_byte, message_binary, close_code, send_close,
   // reply_code, link_open, zero pad
   output logic [47:0]      rsp_tdata,
   output logic             rsp_tlast    // last_byte
);
   logic [31:0] max_ff;
   wscfr_pkg::item_type   qin, qout;
   wscfr_pkg::result_type res;
   logic q_valid, q_ready;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) max_ff <= wscfr_pkg::MAX_MSG_RESET;
      else if (csr_valid) max_ff <= csr_data;
   end

   assign qin.func = req_tuser;
   assign qin.rx_byte = req_tdata;

   wscfr_queue u_queue (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(qin),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(qout)
   );

   wscfr_parser #(.MESSAGE_SIZE_BITS(MESSAGE_SIZE_BITS)) u_parser (
      .clock, .reset, .max_message_size(max_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(qout),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {2'd0, res.link_open, res.reply_code, res.send_close,
                       res.close_code, res.message_binary, res.data_byte,
                       res.event_res};
   assign rsp_tlast = res.last_byte;
endmodule
`default_nettype wire

// ----- verif/websocket_client_frame_receiver_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// WebSocket client frame receiver testbench
// Drives server-to-client byte streams through the frame receiver and checks
// every result item against a cycle-free predictor of the parser. A directed
// table comes first. Random frames follow: well-formed messages, pings,
// pongs and closes, with broken headers and noise mixed in. Random stalls
// are applied on both sides, and the size limit is changed between phases.
// ----------------------------------------------------------------------------
module websocket_client_frame_receiver_tb;

   localparam logic [2:0] PH_HDR0 = 3'd0;
   localparam logic [2:0] PH_HDR1 = 3'd1;
   localparam logic [2:0] PH_EXT  = 3'd2;
   localparam logic [2:0] PH_PAY  = 3'd3;
   localparam logic [2:0] PH_DEAD = 3'd4;

   typedef struct {
      wscfr_pkg::func_type   f;
      logic [7:0]            b;
      bit                    typed;
      wscfr_pkg::result_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tlast;

   // parser state
   logic [2:0]  phase;
   logic        fin;
   logic [3:0]  opcode;
   logic [2:0]  len_left;
   logic [63:0] frame_len;
   logic [63:0] msg_total;
   logic        in_msg;
   logic        bin_msg;
   logic        close_sent;
   logic [15:0] rx_code;
   logic        rsv_bits;
   logic        masked;
   logic [31:0] max_size;

   wscfr_pkg::result_type expected_events[$];
   stim_row_type          directed_rows[$];
   int          error_count = 0;
   int          snd_idle = 0;
   int          rcv_idle = 0;
   int          hold_cycles = 0;
   int          phase_items = 0;

   websocket_client_frame_receiver uut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always #1 clock = ~clock;

   function automatic wscfr_pkg::result_type rsp(wscfr_pkg::event_type ev, logic [7:0] d,
         logic last, logic bin, logic [15:0] cc, logic sc, logic [15:0] rc, logic link);
      wscfr_pkg::result_type r;
      r.event_res = ev;
      r.data_byte = d;
      r.last_byte = last;
      r.message_binary = bin;
      r.close_code = cc;
      r.send_close = sc;
      r.reply_code = rc;
      r.link_open = link;
      return r;
   endfunction

   function automatic wscfr_pkg::result_type emit(wscfr_pkg::event_type ev, logic [7:0] d,
         logic last, logic bin, logic [15:0] cc, logic sc, logic [15:0] rc);
      return rsp(ev, d, last, bin, cc, sc, rc, phase != PH_DEAD);
   endfunction

   function automatic wscfr_pkg::result_type idle_res();
      return emit(wscfr_pkg::EV_NONE, 0, 0, 0, 0, 0, 0);
   endfunction

   function automatic void clear_link();
      phase = PH_HDR0;
      fin = 0;
      opcode = 0;
      len_left = 0;
      frame_len = 0;
      msg_total = 0;
      in_msg = 0;
      bin_msg = 0;
      close_sent = 0;
      rx_code = wscfr_pkg::CODE_ABNORMAL;
      rsv_bits = 0;
      masked = 0;
   endfunction

   function automatic wscfr_pkg::result_type drop_link(wscfr_pkg::event_type ev,
         logic [15:0] reply);
      logic sc;
      sc = !close_sent;
      close_sent = 1;
      phase = PH_DEAD;
      in_msg = 0;
      msg_total = 0;
      return emit(ev, 0, 0, 0, 0, sc, sc ? reply : 16'd0);
   endfunction

   function automatic wscfr_pkg::result_type close_received(logic have_code);
      logic [15:0] code;
      logic [15:0] reply;
      logic        sc;
      code = have_code ? rx_code : wscfr_pkg::CODE_NONE;
      reply = have_code ? rx_code : wscfr_pkg::CODE_NORMAL;
      sc = !close_sent;
      rx_code = code;
      close_sent = 1;
      phase = PH_DEAD;
      in_msg = 0;
      msg_total = 0;
      return emit(wscfr_pkg::EV_CLOSE, 0, 0, 0, code, sc, sc ? reply : 16'd0);
   endfunction

   function automatic wscfr_pkg::result_type header_done();
      logic bin;
      if (frame_len[63] || masked)
         return drop_link(wscfr_pkg::EV_PROTO, wscfr_pkg::CODE_PROTOCOL);
      if (opcode >= 4'd8) begin
         if (!fin || frame_len > 64'd125)
            return drop_link(wscfr_pkg::EV_PROTO, wscfr_pkg::CODE_PROTOCOL);
      end else if (frame_len > {32'd0, max_size} ||
                   msg_total + frame_len > {32'd0, max_size}) begin
         return drop_link(wscfr_pkg::EV_TOO_BIG, wscfr_pkg::CODE_TOO_BIG);
      end
      case (opcode)
         wscfr_pkg::OP_CONT: begin
            if (!in_msg)
               return drop_link(wscfr_pkg::EV_PROTO, wscfr_pkg::CODE_PROTOCOL);
            msg_total = {32'd0, msg_total[31:0] + frame_len[31:0]};
         end
         wscfr_pkg::OP_TEXT, wscfr_pkg::OP_BIN: begin
            if (in_msg)
               return drop_link(wscfr_pkg::EV_PROTO, wscfr_pkg::CODE_PROTOCOL);
            bin_msg = (opcode == wscfr_pkg::OP_BIN);
            in_msg = 1;
            msg_total = {32'd0, frame_len[31:0]};
         end
         wscfr_pkg::OP_CLOSE, wscfr_pkg::OP_PING, wscfr_pkg::OP_PONG: ;
         default: return drop_link(wscfr_pkg::EV_PROTO, wscfr_pkg::CODE_PROTOCOL);
      endcase
      len_left = 0;
      if (frame_len != 0) begin
         phase = PH_PAY;
         return idle_res();
      end
      phase = PH_HDR0;
      if (opcode == wscfr_pkg::OP_CLOSE)
         return close_received(1'b0);
      if (opcode == wscfr_pkg::OP_PING)
         return emit(wscfr_pkg::EV_PONG_NIL, 0, 0, 0, 0, 0, 0);
      if (opcode < 4'd8 && fin) begin
         bin = bin_msg;
         in_msg = 0;
         msg_total = 0;
         return emit(wscfr_pkg::EV_MSG_END, 0, 0, bin, 0, 0, 0);
      end
      return idle_res();
   endfunction

   function automatic wscfr_pkg::result_type payload(logic [7:0] b);
      logic last;
      logic ends;
      frame_len = frame_len - 1;
      last = (frame_len == 0);
      if (last)
         phase = PH_HDR0;
      if (opcode < 4'd8) begin
         ends = last && fin;
         if (ends) begin
            in_msg = 0;
            msg_total = 0;
         end
         return emit(wscfr_pkg::EV_MSG_BYTE, b, ends, bin_msg, 0, 0, 0);
      end
      if (opcode == wscfr_pkg::OP_CLOSE) begin
         if (len_left == 0) begin
            rx_code = {b, 8'd0};
            len_left = 1;
         end else if (len_left == 1) begin
            rx_code = {rx_code[15:8], b};
            len_left = 2;
         end
         return last ? close_received(len_left >= 2) : idle_res();
      end
      if (opcode == wscfr_pkg::OP_PING)
         return emit(wscfr_pkg::EV_PONG, b, last, 0, 0, 0, 0);
      return idle_res();
   endfunction

   function automatic wscfr_pkg::result_type parse_byte(logic [1:0] f, logic [7:0] b);
      if (f == wscfr_pkg::FUNC_LCLOSE) begin
         close_sent = 1;
         return idle_res();
      end
      if (f == wscfr_pkg::FUNC_NEWCON) begin
         clear_link();
         return idle_res();
      end
      if (f != wscfr_pkg::FUNC_BYTE || phase == PH_DEAD)
         return idle_res();
      case (phase)
         PH_HDR0: begin
            fin = b[7];
            opcode = b[3:0];
            rsv_bits = |b[6:4];
            phase = PH_HDR1;
            return idle_res();
         end
         PH_HDR1: begin
            if (rsv_bits)
               return drop_link(wscfr_pkg::EV_PROTO, wscfr_pkg::CODE_PROTOCOL);
            masked = b[7];
            frame_len = 0;
            if (b[6:0] == 7'd126) begin
               len_left = 1;
               phase = PH_EXT;
               return idle_res();
            end
            if (b[6:0] == 7'd127) begin
               len_left = 7;
               phase = PH_EXT;
               return idle_res();
            end
            frame_len = {57'd0, b[6:0]};
            return header_done();
         end
         PH_EXT: begin
            frame_len = {frame_len[55:0], b};
            if (len_left == 0)
               return header_done();
            len_left = len_left - 1;
            return idle_res();
         end
         PH_PAY: begin
            if (frame_len == 0) begin
               phase = PH_HDR0;
               return idle_res();
            end
            return payload(b);
         end
         default: return idle_res();
      endcase
   endfunction

   task automatic send(wscfr_pkg::func_type f, logic [7:0] b, bit typed = 0,
         wscfr_pkg::result_type want = '0);
      if (snd_idle > 0 && $urandom_range(0, 99) < snd_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < snd_idle)
            @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= f;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      if (typed) begin
         void'(parse_byte(f, b));
         expected_events.push_back(want);
      end else begin
         expected_events.push_back(parse_byte(f, b));
      end
      phase_items++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max(logic [31:0] v);
      drain();
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      max_size = v;
   endtask

   task automatic send_header(logic f, logic [3:0] op, logic [63:0] len);
      int n;
      send(wscfr_pkg::FUNC_BYTE, {f, 3'b000, op});
      if (len < 126 && $urandom_range(0, 5) != 0) begin
         send(wscfr_pkg::FUNC_BYTE, {1'b0, len[6:0]});
      end else if (len < 65536 && $urandom_range(0, 3) != 0) begin
         send(wscfr_pkg::FUNC_BYTE, 8'd126);
         send(wscfr_pkg::FUNC_BYTE, len[15:8]);
         send(wscfr_pkg::FUNC_BYTE, len[7:0]);
      end else begin
         send(wscfr_pkg::FUNC_BYTE, 8'd127);
         for (n = 7; n >= 0; n--)
            send(wscfr_pkg::FUNC_BYTE, len[n*8 +: 8]);
      end
   endtask

   task automatic send_payload(int len);
      repeat (len) send(wscfr_pkg::FUNC_BYTE, 8'($urandom));
   endtask

   function automatic int pick_len(int top);
      return ($urandom_range(0, 7) == 0) ? $urandom_range(0, top) : $urandom_range(0, 12);
   endfunction

   task automatic random_frame();
      int kind;
      int frags;
      int len;
      int i;
      logic [15:0] code;
      if (phase == PH_DEAD && $urandom_range(0, 9) != 0)
         send(wscfr_pkg::FUNC_NEWCON, 8'($urandom));
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         frags = $urandom_range(1, 3);
         for (i = 0; i < frags; i++) begin
            if (i > 0 && $urandom_range(0, 3) == 0) begin
               len = $urandom_range(0, 4);
               send_header(1'b1, wscfr_pkg::OP_PING, 64'(len));
               send_payload(len);
            end
            len = pick_len(300);
            send_header(i == frags - 1, i == 0 ?
                        ($urandom_range(0, 1) ? wscfr_pkg::OP_BIN : wscfr_pkg::OP_TEXT)
                        : wscfr_pkg::OP_CONT, 64'(len));
            send_payload(len);
         end
      end else if (kind < 60) begin
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(120, 130) : $urandom_range(0, 10);
         send_header(1'b1, wscfr_pkg::OP_PING, 64'(len));
         send_payload(len);
      end else if (kind < 65) begin
         len = $urandom_range(0, 5);
         send_header(1'b1, wscfr_pkg::OP_PONG, 64'(len));
         send_payload(len);
      end else if (kind < 73) begin
         len = $urandom_range(0, 3) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 8);
         code = 16'($urandom);
         send_header(1'b1, wscfr_pkg::OP_CLOSE, 64'(len));
         if (len > 0) send(wscfr_pkg::FUNC_BYTE, code[15:8]);
         if (len > 1) send(wscfr_pkg::FUNC_BYTE, code[7:0]);
         if (len > 2) send_payload(len - 2);
      end else if (kind < 83) begin
         send(wscfr_pkg::FUNC_BYTE, 8'($urandom));
         send(wscfr_pkg::FUNC_BYTE, 8'($urandom));
         send_payload($urandom_range(0, 6));
      end else if (kind < 88) begin
         send_header(1'b1, wscfr_pkg::OP_BIN, {1'b1, 31'($urandom), 32'($urandom)});
      end else if (kind < 92) begin
         send(wscfr_pkg::FUNC_LCLOSE, 8'($urandom));
      end else if (kind < 96) begin
         send(wscfr_pkg::FUNC_NEWCON, 8'($urandom));
      end else begin
         send(wscfr_pkg::func_type'($urandom_range(0, 3)), 8'($urandom));
      end
   endtask

   task automatic row(wscfr_pkg::func_type f, logic [7:0] b, bit typed = 0,
         wscfr_pkg::result_type want = '0);
      stim_row_type r;
      r.f = f;
      r.b = b;
      r.typed = typed;
      r.want = want;
      directed_rows.push_back(r);
   endtask

   always @(posedge clock) begin
      wscfr_pkg::result_type got;
      wscfr_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.event_res = rsp_tdata[2:0];
         got.data_byte = rsp_tdata[10:3];
         got.last_byte = rsp_tlast;
         got.message_binary = rsp_tdata[11];
         got.close_code = rsp_tdata[27:12];
         got.send_close = rsp_tdata[28];
         got.reply_code = rsp_tdata[44:29];
         got.link_open = rsp_tdata[45];
         if (expected_events.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item ev=%0d data=%h", $realtime, got.event_res,
                     got.data_byte);
         end else begin
            want = expected_events.pop_front();
            if (got !== want) begin
               error_count++;
               $display("%0t: mismatch exp ev=%0d d=%h l=%b bin=%b cc=%0d sc=%b rc=%0d lo=%b",
                        $realtime, want.event_res, want.data_byte, want.last_byte,
                        want.message_binary, want.close_code, want.send_close,
                        want.reply_code, want.link_open);
               $display("%0t:          got ev=%0d d=%h l=%b bin=%b cc=%0d sc=%b rc=%0d lo=%b",
                        $realtime, got.event_res, got.data_byte, got.last_byte,
                        got.message_binary, got.close_code, got.send_close,
                        got.reply_code, got.link_open);
            end
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(rcv_idle > 0 && $urandom_range(0, 99) < rcv_idle);
      end
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      int p;
      clear_link();
      max_size = wscfr_pkg::MAX_MSG_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      snd_idle = 38;
      rcv_idle = 56;

      row(wscfr_pkg::FUNC_BYTE, 8'h81);
      row(wscfr_pkg::FUNC_BYTE, 8'h02);
      row(wscfr_pkg::FUNC_BYTE, 8'h00);
      row(wscfr_pkg::FUNC_BYTE, 8'hFF, 1, rsp(wscfr_pkg::EV_MSG_BYTE, 8'hFF, 1, 0, 0, 0, 0, 1));
      row(wscfr_pkg::FUNC_BYTE, 8'h82);
      row(wscfr_pkg::FUNC_BYTE, 8'h00, 1, rsp(wscfr_pkg::EV_MSG_END, 0, 0, 1, 0, 0, 0, 1));
      row(wscfr_pkg::FUNC_BYTE, 8'h89);
      row(wscfr_pkg::FUNC_BYTE, 8'h01);
      row(wscfr_pkg::FUNC_BYTE, 8'hA5, 1, rsp(wscfr_pkg::EV_PONG, 8'hA5, 1, 0, 0, 0, 0, 1));
      row(wscfr_pkg::FUNC_BYTE, 8'h89);
      row(wscfr_pkg::FUNC_BYTE, 8'h00, 1, rsp(wscfr_pkg::EV_PONG_NIL, 0, 0, 0, 0, 0, 0, 1));
      row(wscfr_pkg::FUNC_BYTE, 8'h80);
      row(wscfr_pkg::FUNC_BYTE, 8'h00, 1,
          rsp(wscfr_pkg::EV_PROTO, 0, 0, 0, 0, 1, wscfr_pkg::CODE_PROTOCOL, 0));
      row(wscfr_pkg::FUNC_BYTE, 8'h81, 1, rsp(wscfr_pkg::EV_NONE, 0, 0, 0, 0, 0, 0, 0));
      row(wscfr_pkg::FUNC_NONE, 8'h5A);
      row(wscfr_pkg::FUNC_NEWCON, 8'h00);
      row(wscfr_pkg::FUNC_LCLOSE, 8'hFF);
      row(wscfr_pkg::FUNC_BYTE, 8'hF1);
      row(wscfr_pkg::FUNC_BYTE, 8'hFE, 1, rsp(wscfr_pkg::EV_PROTO, 0, 0, 0, 0, 0, 0, 0));
      row(wscfr_pkg::FUNC_NEWCON, 8'hFF);
      row(wscfr_pkg::FUNC_BYTE, 8'h88);
      row(wscfr_pkg::FUNC_BYTE, 8'h02);
      row(wscfr_pkg::FUNC_BYTE, 8'h03);
      row(wscfr_pkg::FUNC_BYTE, 8'hE8, 1, rsp(wscfr_pkg::EV_CLOSE, 0, 0, 0,
          wscfr_pkg::CODE_NORMAL, 1, wscfr_pkg::CODE_NORMAL, 0));
      row(wscfr_pkg::FUNC_NEWCON, 8'h00);
      row(wscfr_pkg::FUNC_BYTE, 8'h88);
      row(wscfr_pkg::FUNC_BYTE, 8'h00, 1, rsp(wscfr_pkg::EV_CLOSE, 0, 0, 0,
          wscfr_pkg::CODE_NONE, 1, wscfr_pkg::CODE_NORMAL, 0));
      foreach (directed_rows[i])
         send(directed_rows[i].f, directed_rows[i].b, directed_rows[i].typed,
              directed_rows[i].want);

      for (p = 0; p < 4; p++) begin
         case (p)
            0: write_max(32'd0);
            1: begin
               write_max(32'hFFFF_FFFF);
               snd_idle = 56;
               rcv_idle = 38;
            end
            2: begin
               write_max(32'd40);
               snd_idle = 0;
               rcv_idle = 0;
               hold_cycles = 300;
            end
            default: write_max($urandom_range(0, 300));
         endcase
         send(wscfr_pkg::FUNC_NEWCON, 8'h00);
         phase_items = 0;
         while (phase_items < 250)
            random_frame();
      end

      drain();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
